// File: src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// File: src/spa_slp_pkg.sv
`default_nettype none

package spa_slp_pkg;

    // Character codes seen on the link
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    // Line identifiers, first character in the upper byte
    localparam logic [15:0] IDENT_R5 = 16'h5235;
    localparam logic [15:0] IDENT_R6 = 16'h5236;
    localparam logic [15:0] IDENT_RG = 16'h5247;

    // Selected field numbers
    localparam logic [4:0] FIELD_R5_HEATER = 5'd12;
    localparam logic [4:0] FIELD_R5_WATER  = 5'd15;
    localparam logic [4:0] FIELD_R6_TARGET = 5'd8;
    localparam logic [4:0] FIELD_RG_LOCK   = 5'd12;
    localparam logic [4:0] FIELD_MAX       = 5'd31;

    // Attribute codes
    localparam logic [1:0] ATTR_HEATER = 2'd0;
    localparam logic [1:0] ATTR_WATER  = 2'd1;
    localparam logic [1:0] ATTR_TARGET = 2'd2;
    localparam logic [1:0] ATTR_LOCK   = 2'd3;

    localparam logic [15:0] TIMEOUT_RESET = 16'd300;

    // Result queue geometry
    localparam int unsigned FifoDepth = 4;
    localparam int unsigned FifoAw    = $clog2(FifoDepth);

    typedef struct packed {
        logic        valid_res;
        logic [1:0]  attribute;
        logic [15:0] value;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

// File: src/spa_slp_fifo.sv
`default_nettype none

`include "assert_macros.svh"

module spa_slp_fifo (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire  [1:0]            i_push_cnt,
    input  wire spa_slp_pkg::t_result i_push0,
    input  wire spa_slp_pkg::t_result i_push1,
    output logic                  o_room2,
    output logic                  o_valid,
    input  wire                   i_ready,
    output spa_slp_pkg::t_result  o_head
);

    localparam int unsigned Aw = spa_slp_pkg::FifoAw;
    localparam logic [Aw:0] DepthC = (Aw + 1)'(spa_slp_pkg::FifoDepth);

    spa_slp_pkg::t_result r_mem [spa_slp_pkg::FifoDepth];
    logic [Aw-1:0] r_wr_ptr, n_wr_ptr;
    logic [Aw-1:0] r_rd_ptr, n_rd_ptr;
    logic [Aw:0]   r_count, n_count;
    logic          pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_room2 = (r_count <= DepthC - (Aw + 1)'(2));

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr + Aw'(i_push_cnt);
        n_rd_ptr = pop ? r_rd_ptr + Aw'(1) : r_rd_ptr;
        n_count  = r_count + (Aw + 1)'(i_push_cnt) - (Aw + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store up to two results per cycle
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr_ptr + Aw'(1)] <= i_push1;
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, (r_count + (Aw + 1)'(i_push_cnt)) > DepthC)
    `ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > DepthC)
    `ASSERT_AT(a_pop_drains, i_clk, i_rst_n, (pop && i_push_cnt == 2'd0) |=> (r_count == $past(r_count) - (Aw + 1)'(1)))

endmodule

`default_nettype wire

// File: src/spa_status_line_parser_core.sv
// Channel   Dir  Bits of tdata / tuser / tlast            Transfer when
// s_axis    in   tdata[7:0] rx_byte; tuser[0] op           tvalid && tready
// m_axis    out  tdata[15:0] value; tuser[1:0] attribute,  tvalid && tready
//                tuser[2] valid_res; tlast last
// cfg       in   i_cfg_wr_data timeout_ms                  i_cfg_wr_en
//
// One input transfer per cycle is taken unless a carriage return waits in the
// input register until the four-entry result queue has room for two; once the
// parser takes it, up to two held results land in the queue at once, the next
// edge. Results leave at one per cycle while m_axis is ready. Reset is
// synchronous, active low, and clears all control state. A stall on m_axis backs
// up s_axis only while a carriage return waits for the queue to hold two or fewer
// results; other items never wait.
`default_nettype none

`include "assert_macros.svh"

module spa_status_line_parser_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [15:0] i_cfg_wr_data,   // timeout_ms
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,    // [7:0] rx_byte
    input  wire         s_axis_tuser,    // [0] op
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,    // [15:0] value
    output logic [2:0]  m_axis_tuser,    // [1:0] attribute, [2] valid_res
    output logic        m_axis_tlast
);

    typedef enum logic [2:0] {
        PH_AWAIT_NL,
        PH_AWAIT_COMMA,
        PH_IDENT,
        PH_FIELDS,
        PH_SKIP
    } t_phase;

    typedef struct packed {
        logic [15:0] mag;
        logic        started;
        logic        neg;
        logic        digits;
        logic        bad;
        logic        ended;
    } t_accum;

    localparam t_accum AccumClear = '0;

    // Input register
    logic        r_in_valid;
    logic        r_in_op;
    logic [7:0]  r_in_byte;

    // Parser state
    logic [15:0] r_timeout;
    logic [15:0] r_idle, n_idle;
    t_phase      r_phase, n_phase;
    logic [15:0] r_ident, n_ident;
    logic [1:0]  r_idlen, n_idlen;
    logic [4:0]  r_fieldno, n_fieldno;
    t_accum      r_acc, n_acc;
    logic [1:0]  r_pend_cnt, n_pend_cnt;
    spa_slp_pkg::t_result r_pend [2];

    // Line state after a possible timeout drop
    t_phase      p_phase;
    logic [15:0] p_ident;
    logic [1:0]  p_idlen;
    logic [4:0]  p_fieldno;
    t_accum      p_acc;
    logic [1:0]  p_pend_cnt;

    logic        consume;
    logic        room2;
    logic        timed_out;
    logic        is_cr;
    logic        is_digit;
    logic [3:0]  digit;
    logic [19:0] mag_next;
    logic        sel_ok;
    logic [1:0]  sel_attr;
    logic        num_ok;
    logic [15:0] num_val;
    logic        pend_we;
    spa_slp_pkg::t_result pend_wdata;
    logic [1:0]  push_cnt;
    spa_slp_pkg::t_result push0, push1, head;

    assign is_cr   = (r_in_byte == spa_slp_pkg::CHAR_CR);
    assign consume = r_in_valid && (r_in_op || !is_cr || room2);
    assign s_axis_tready = !r_in_valid || consume;

    // Hold the accepted item until the parser takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= spa_slp_pkg::TIMEOUT_RESET;
        end else if (i_cfg_wr_en) begin
            r_timeout <= i_cfg_wr_data;
        end
    end

    // Drop the partial line when the gap since the last byte is too long
    always_comb begin
        timed_out = (r_idle > r_timeout);
        if (timed_out) begin
            p_phase    = PH_AWAIT_NL;
            p_ident    = '0;
            p_idlen    = '0;
            p_fieldno  = '0;
            p_acc      = AccumClear;
            p_pend_cnt = '0;
        end else begin
            p_phase    = r_phase;
            p_ident    = r_ident;
            p_idlen    = r_idlen;
            p_fieldno  = r_fieldno;
            p_acc      = r_acc;
            p_pend_cnt = r_pend_cnt;
        end
    end

    // Digit accumulate with saturation at 16 bits
    always_comb begin
        is_digit = r_in_byte inside {[spa_slp_pkg::CHAR_ZERO:spa_slp_pkg::CHAR_NINE]};
        digit    = 4'(r_in_byte - spa_slp_pkg::CHAR_ZERO);
        mag_next = {1'b0, p_acc.mag, 3'b000} + {3'b000, p_acc.mag, 1'b0} + {16'd0, digit};
    end

    // Select attribute from identifier and field number
    always_comb begin
        sel_ok   = 1'b0;
        sel_attr = spa_slp_pkg::ATTR_HEATER;
        if (p_idlen == 2'd2) begin
            case (p_ident)
                spa_slp_pkg::IDENT_R5: begin
                    if (p_fieldno == spa_slp_pkg::FIELD_R5_HEATER) begin
                        sel_ok   = 1'b1;
                        sel_attr = spa_slp_pkg::ATTR_HEATER;
                    end else if (p_fieldno == spa_slp_pkg::FIELD_R5_WATER) begin
                        sel_ok   = 1'b1;
                        sel_attr = spa_slp_pkg::ATTR_WATER;
                    end
                end
                spa_slp_pkg::IDENT_R6: begin
                    if (p_fieldno == spa_slp_pkg::FIELD_R6_TARGET) begin
                        sel_ok   = 1'b1;
                        sel_attr = spa_slp_pkg::ATTR_TARGET;
                    end
                end
                spa_slp_pkg::IDENT_RG: begin
                    if (p_fieldno == spa_slp_pkg::FIELD_RG_LOCK) begin
                        sel_ok   = 1'b1;
                        sel_attr = spa_slp_pkg::ATTR_LOCK;
                    end
                end
                default: begin
                    sel_ok = 1'b0;
                end
            endcase
        end
    end

    // Convert the finished field to a saturated signed value, or to 0/1 for the heater
    always_comb begin
        num_ok  = p_acc.digits && !p_acc.bad;
        num_val = '0;
        if (num_ok) begin
            if (p_acc.neg) begin
                num_val = (p_acc.mag > 16'd32768) ? 16'h8000 : 16'(17'h10000 - {1'b0, p_acc.mag});
            end else begin
                num_val = (p_acc.mag > 16'd32767) ? 16'h7FFF : p_acc.mag;
            end
            if (sel_attr == spa_slp_pkg::ATTR_HEATER) begin
                num_val = {15'd0, (num_val != 16'd0)};
            end
        end
        pend_wdata.valid_res = num_ok;
        pend_wdata.attribute = sel_attr;
        pend_wdata.value     = num_val;
        pend_wdata.last      = 1'b0;
    end

    // Next-state logic for one item
    always_comb begin
        n_idle     = r_idle;
        n_phase    = r_phase;
        n_ident    = r_ident;
        n_idlen    = r_idlen;
        n_fieldno  = r_fieldno;
        n_acc      = r_acc;
        n_pend_cnt = r_pend_cnt;
        pend_we    = 1'b0;
        push_cnt   = 2'd0;
        if (consume) begin
            if (r_in_op) begin
                if (r_idle != 16'hFFFF) begin
                    n_idle = r_idle + 16'd1;
                end
            end else begin
                n_idle     = '0;
                n_phase    = p_phase;
                n_ident    = p_ident;
                n_idlen    = p_idlen;
                n_fieldno  = p_fieldno;
                n_acc      = p_acc;
                n_pend_cnt = p_pend_cnt;
                if (is_cr) begin
                    // Release held results and start over
                    push_cnt   = p_pend_cnt;
                    n_phase    = PH_AWAIT_NL;
                    n_ident    = '0;
                    n_idlen    = '0;
                    n_fieldno  = '0;
                    n_acc      = AccumClear;
                    n_pend_cnt = '0;
                end else begin
                    case (p_phase)
                        PH_AWAIT_NL: begin
                            n_phase = (r_in_byte == spa_slp_pkg::CHAR_NL) ? PH_AWAIT_COMMA : PH_SKIP;
                        end
                        PH_AWAIT_COMMA: begin
                            n_phase = (r_in_byte == spa_slp_pkg::CHAR_COMMA) ? PH_IDENT : PH_SKIP;
                        end
                        PH_IDENT: begin
                            if (r_in_byte == spa_slp_pkg::CHAR_COMMA) begin
                                n_phase   = PH_FIELDS;
                                n_fieldno = 5'd1;
                                n_acc     = AccumClear;
                            end else if (p_idlen < 2'd2) begin
                                n_ident = {p_ident[7:0], r_in_byte};
                                n_idlen = p_idlen + 2'd1;
                            end else begin
                                n_idlen = 2'd3;
                            end
                        end
                        PH_FIELDS: begin
                            if (r_in_byte == spa_slp_pkg::CHAR_COMMA) begin
                                if (sel_ok && p_pend_cnt < 2'd2) begin
                                    pend_we    = 1'b1;
                                    n_pend_cnt = p_pend_cnt + 2'd1;
                                end
                                if (p_fieldno < spa_slp_pkg::FIELD_MAX) begin
                                    n_fieldno = p_fieldno + 5'd1;
                                end
                                n_acc = AccumClear;
                            end else if (!p_acc.ended) begin
                                if (r_in_byte == spa_slp_pkg::CHAR_NUL) begin
                                    n_acc.ended = 1'b1;
                                end else begin
                                    if (r_in_byte == spa_slp_pkg::CHAR_MINUS && !p_acc.started) begin
                                        n_acc.neg = 1'b1;
                                    end else if (is_digit) begin
                                        n_acc.digits = 1'b1;
                                        n_acc.mag    = (mag_next > 20'h0FFFF) ? 16'hFFFF
                                                                               : mag_next[15:0];
                                    end else begin
                                        n_acc.bad = 1'b1;
                                    end
                                    n_acc.started = 1'b1;
                                end
                            end
                        end
                        default: begin
                            n_phase = p_phase;
                        end
                    endcase
                end
            end
        end
    end

    // Hold parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle     <= 16'hFFFF;
            r_phase    <= PH_AWAIT_NL;
            r_ident    <= '0;
            r_idlen    <= '0;
            r_fieldno  <= '0;
            r_acc      <= AccumClear;
            r_pend_cnt <= '0;
        end else begin
            r_idle     <= n_idle;
            r_phase    <= n_phase;
            r_ident    <= n_ident;
            r_idlen    <= n_idlen;
            r_fieldno  <= n_fieldno;
            r_acc      <= n_acc;
            r_pend_cnt <= n_pend_cnt;
        end
    end

    // Held field results, written in field order
    always_ff @(posedge i_clk) begin
        if (pend_we) begin
            r_pend[p_pend_cnt[0]] <= pend_wdata;
        end
    end

    // Mark the final result of the line
    always_comb begin
        push0      = r_pend[0];
        push0.last = (push_cnt == 2'd1);
        push1      = r_pend[1];
        push1.last = 1'b1;
    end

    spa_slp_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_push0    (push0),
        .i_push1    (push1),
        .o_room2    (room2),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_head     (head)
    );

    assign m_axis_tdata = head.value;
    assign m_axis_tuser = {head.valid_res, head.attribute};
    assign m_axis_tlast = head.last;

    `ASSERT_NEVER(a_pend_range, i_clk, i_rst_n, r_pend_cnt > 2'd2)
    `ASSERT_AT(a_tick_no_push, i_clk, i_rst_n, (r_in_valid && r_in_op) |-> (push_cnt == 2'd0))
    `ASSERT_AT(a_cr_has_room, i_clk, i_rst_n, (push_cnt != 2'd0) |-> room2)
    `ASSERT_NEVER(a_field_nonzero, i_clk, i_rst_n, (r_phase == PH_FIELDS) && (r_fieldno == 5'd0))

endmodule

`default_nettype wire

// File: bench/tb.sv
`default_nettype none

module tb;
    import spa_slp_pkg::*;

    localparam int SETTLE_CYC     = 8;
    localparam int TAIL_CYC       = 20;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum logic [2:0] {
        PH_NL, PH_COMMA, PH_IDENT, PH_FIELD, PH_SKIP
    } line_phase_t;

    typedef enum logic [1:0] {ACT_ITEM, ACT_CFG, ACT_DRAIN} act_t;

    typedef enum logic [1:0] {PACE_FLOW, PACE_HOLD, PACE_JITTER} pace_t;

    typedef struct {
        act_t        kind;
        bit          op;
        logic [7:0]  rx;
        logic [15:0] cfg_val;
    } stim_t;

    // Clock, reset and block inputs, all known from time zero
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tready = 1'b0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [15:0] m_axis_tdata;
    wire  [2:0]  m_axis_tuser;
    wire         m_axis_tlast;

    // Shadow copy of the line decoder state
    logic [15:0] tmo_ms      = TIMEOUT_RESET;
    logic [15:0] idle_ms     = 16'hFFFF;
    line_phase_t line_phase  = PH_NL;
    logic [15:0] line_ident  = '0;
    logic [1:0]  ident_len   = '0;
    logic [4:0]  field_no    = '0;
    int unsigned acc_mag     = 0;
    bit          acc_started = 1'b0;
    bit          acc_neg     = 1'b0;
    bit          acc_digits  = 1'b0;
    bit          acc_bad     = 1'b0;
    bit          acc_ended   = 1'b0;
    t_result     held_attrs[2];
    int          held_cnt    = 0;

    t_result     expected_attrs[$];
    stim_t       stim_q[$];
    int          gen_cnt      = 0;
    int          sent_cnt     = 0;
    int          in_acc_cnt   = 0;
    int          mismatch_cnt = 0;
    int          quiet_cyc    = 0;

    // Sender burst and receiver pacing state
    int          burst_left = 1;
    int          gap_left   = 0;
    int          settle     = 0;
    pace_t       rdy_mode   = PACE_FLOW;
    int          rdy_left   = 0;

    spa_status_line_parser_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // Drop the partial field
    function automatic void clear_accum();
        acc_mag     = 0;
        acc_started = 1'b0;
        acc_neg     = 1'b0;
        acc_digits  = 1'b0;
        acc_bad     = 1'b0;
        acc_ended   = 1'b0;
    endfunction

    // Drop the partial line and its held values
    function automatic void clear_line();
        line_phase = PH_NL;
        line_ident = '0;
        ident_len  = '0;
        field_no   = '0;
        clear_accum();
        held_cnt   = 0;
    endfunction

    // Map the current identifier and field number to an attribute
    function automatic bit pick_attr(output logic [1:0] a);
        a = ATTR_HEATER;
        if (ident_len != 2'd2) return 1'b0;
        if (line_ident == IDENT_R5 && field_no == FIELD_R5_HEATER) begin
            a = ATTR_HEATER;
            return 1'b1;
        end
        if (line_ident == IDENT_R5 && field_no == FIELD_R5_WATER) begin
            a = ATTR_WATER;
            return 1'b1;
        end
        if (line_ident == IDENT_R6 && field_no == FIELD_R6_TARGET) begin
            a = ATTR_TARGET;
            return 1'b1;
        end
        if (line_ident == IDENT_RG && field_no == FIELD_RG_LOCK) begin
            a = ATTR_LOCK;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the shadow decoder by one byte or tick; queue attribute reports
    task automatic parse_status_item(input bit op, input logic [7:0] rx);
        logic [1:0]  a;
        logic [15:0] v;
        int unsigned m;
        bit          ok;
        t_result     r;
        if (op) begin
            if (idle_ms != 16'hFFFF) idle_ms++;
        end else begin
            if (idle_ms > tmo_ms) clear_line();
            idle_ms = '0;
            if (rx == CHAR_CR) begin
                for (int k = 0; k < held_cnt; k++) begin
                    r      = held_attrs[k];
                    r.last = (k == held_cnt - 1);
                    expected_attrs = {expected_attrs, r};
                end
                clear_line();
            end else begin
                case (line_phase)
                    PH_NL: begin
                        line_phase = (rx == CHAR_NL) ? PH_COMMA : PH_SKIP;
                    end
                    PH_COMMA: begin
                        line_phase = (rx == CHAR_COMMA) ? PH_IDENT : PH_SKIP;
                    end
                    PH_IDENT: begin
                        if (rx == CHAR_COMMA) begin
                            line_phase = PH_FIELD;
                            field_no   = 5'd1;
                            clear_accum();
                        end else if (ident_len < 2'd2) begin
                            line_ident = {line_ident[7:0], rx};
                            ident_len++;
                        end else begin
                            ident_len = 2'd3;
                        end
                    end
                    PH_FIELD: begin
                        if (rx == CHAR_COMMA) begin
                            // Close the field: saturate and hold if selected
                            if (pick_attr(a) && held_cnt < 2) begin
                                ok = acc_digits && !acc_bad;
                                v  = '0;
                                if (ok) begin
                                    if (acc_neg) begin
                                        m = (acc_mag > 32768) ? 32768 : acc_mag;
                                        v = 16'(32'h10000 - m);
                                    end else begin
                                        v = 16'((acc_mag > 32767) ? 32767 : acc_mag);
                                    end
                                    if (a == ATTR_HEATER) v = {15'd0, v != 16'd0};
                                end
                                held_attrs[held_cnt] = '{valid_res: ok, attribute: a,
                                                         value: v, last: 1'b0};
                                held_cnt++;
                            end
                            if (field_no < FIELD_MAX) field_no++;
                            clear_accum();
                        end else if (!acc_ended) begin
                            if (rx == CHAR_NUL) begin
                                acc_ended = 1'b1;
                            end else begin
                                if (rx == CHAR_MINUS && !acc_started) begin
                                    acc_neg = 1'b1;
                                end else if (rx >= CHAR_ZERO && rx <= CHAR_NINE) begin
                                    acc_digits = 1'b1;
                                    acc_mag    = acc_mag * 10 + (rx - CHAR_ZERO);
                                    if (acc_mag > 32'hFFFF) acc_mag = 32'hFFFF;
                                end else begin
                                    acc_bad = 1'b1;
                                end
                                acc_started = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    endtask

    task automatic report_err(input string what, input t_result got, input t_result want);
        $display("tb: %s: got attr %0d ok %0b val %0d last %0b, want attr %0d ok %0b val %0d last %0b",
                 what, got.attribute, got.valid_res, $signed(got.value), got.last,
                 want.attribute, want.valid_res, $signed(want.value), want.last);
        mismatch_cnt++;
    endtask

    // Append one entry to the pending stimulus
    task automatic enqueue_stim(input stim_t s);
        stim_q = {stim_q, s};
    endtask

    // Stimulus builders
    task automatic push_byte(input logic [7:0] b);
        enqueue_stim('{kind: ACT_ITEM, op: 1'b0, rx: b, cfg_val: '0});
        gen_cnt++;
    endtask

    task automatic push_ticks(input int n);
        repeat (n) begin
            enqueue_stim('{kind: ACT_ITEM, op: 1'b1, rx: 8'($urandom_range(0, 255)),
                           cfg_val: '0});
            gen_cnt++;
        end
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_cfg(input logic [15:0] val);
        enqueue_stim('{kind: ACT_CFG, op: 1'b0, rx: '0, cfg_val: val});
    endtask

    task automatic push_drain();
        enqueue_stim('{kind: ACT_DRAIN, op: 1'b0, rx: '0, cfg_val: '0});
    endtask

    function automatic logic [7:0] rand_plain();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CHAR_CR || b == CHAR_COMMA);
        return b;
    endfunction

    task automatic push_digits(input int n);
        repeat (n) push_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // Line with selected fields fa and fb set, all others filler
    task automatic dir_line(input string id, input int nf, input int fa, input string va,
                            input int fb, input string vb);
        push_text("\n,");
        push_text(id);
        push_byte(CHAR_COMMA);
        for (int i = 1; i <= nf; i++) begin
            if (i == fa) push_text(va);
            else if (i == fb) push_text(vb);
            else push_text("1");
            push_byte(CHAR_COMMA);
        end
        push_text("77");
        push_byte(CHAR_CR);
    endtask

    // Random field text without its comma
    task automatic rand_field();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                if ($urandom_range(0, 2) == 0) push_byte(CHAR_MINUS);
                push_digits(($urandom_range(0, 4) == 0) ? $urandom_range(5, 7)
                                                       : $urandom_range(1, 4));
            end
            5: ;
            6: push_byte(CHAR_MINUS);
            7: begin
                push_digits($urandom_range(0, 2));
                push_byte(CHAR_MINUS);
                push_digits($urandom_range(0, 2));
            end
            8: begin
                push_digits($urandom_range(0, 2));
                push_byte(rand_plain());
                push_digits($urandom_range(0, 2));
            end
            default: begin
                push_digits($urandom_range(0, 3));
                push_byte(CHAR_NUL);
                repeat ($urandom_range(0, 3)) push_byte(rand_plain());
            end
        endcase
    endtask

    // Well-formed status line with random identifier and content
    task automatic rand_line(output bit hit);
        int need;
        int nf;
        int tick_at;
        need = 0;
        push_text("\n,");
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                push_text("R5");
                need = 12;
            end
            3, 4: begin
                push_text("R6");
                need = 8;
            end
            5, 6: begin
                push_text("RG");
                need = 12;
            end
            7: begin
                push_byte("R");
                push_byte(rand_plain());
            end
            8: begin
                push_text("R5");
                push_byte(rand_plain());
            end
            default: repeat ($urandom_range(0, 1)) push_byte(rand_plain());
        endcase
        push_byte(CHAR_COMMA);
        if (need != 0 && $urandom_range(0, 4) != 0) nf = $urandom_range(need, 16);
        else nf = $urandom_range(0, 33);
        tick_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, nf + 1) : 0;
        for (int i = 1; i <= nf; i++) begin
            if (i == tick_at) push_ticks($urandom_range(1, 6));
            if (i == 8 || i == 12 || i == 15) rand_field();
            else push_digits($urandom_range(0, 2));
            push_byte(CHAR_COMMA);
        end
        if (tick_at == nf + 1) push_ticks($urandom_range(1, 6));
        repeat ($urandom_range(0, 3)) push_byte(rand_plain());
        push_byte(CHAR_CR);
        hit = (need != 0 && nf >= need);
    endtask

    // Garbage bytes, broken line starts and idle ticks
    task automatic rand_noise();
        case ($urandom_range(0, 3))
            0: repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
            1: begin
                push_byte(CHAR_NL);
                push_byte(rand_plain());
                push_text("R6,1,1,1,1,1,1,1,5,");
                push_byte(CHAR_CR);
            end
            2: begin
                push_byte(rand_plain());
                push_text("\n,R6,1,1,1,1,1,1,1,5,");
                push_byte(CHAR_CR);
            end
            default: push_ticks($urandom_range(1, 5));
        endcase
    endtask

    task automatic run_phase(input int n_items, input int n_hits);
        int  start;
        int  hits;
        bit  hit;
        start = gen_cnt;
        hits  = 0;
        while (gen_cnt - start < n_items || hits < n_hits) begin
            if ($urandom_range(0, 9) < 7) begin
                rand_line(hit);
                if (hit) hits++;
            end else begin
                rand_noise();
            end
        end
    endtask

    // Driver: hold the transfer until taken, then feed the next pending entry
    always @(negedge i_clk) begin : feed_proc
        logic        nv;
        logic [7:0]  nd;
        logic        nu;
        logic        ncfg;
        logic [15:0] ncd;
        stim_t       act;
        nv   = s_axis_tvalid;
        nd   = s_axis_tdata;
        nu   = s_axis_tuser;
        ncfg = 1'b0;
        ncd  = i_cfg_wr_data;
        if (i_rst_n && !(s_axis_tvalid && in_acc_cnt != sent_cnt)) begin
            nv = 1'b0;
            if (gap_left != 0) begin
                gap_left--;
            end else if (stim_q.size() != 0) begin
                act = stim_q[0];
                if (act.kind == ACT_ITEM) begin
                    void'(stim_q.pop_front());
                    nv = 1'b1;
                    nd = act.rx;
                    nu = act.op;
                    sent_cnt++;
                    settle = 0;
                    burst_left--;
                    if (burst_left <= 0) begin
                        if ($urandom_range(0, 3) == 0) begin
                            burst_left = $urandom_range(50, 300);
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 20);
                            gap_left   = $urandom_range(0, 12);
                        end
                    end
                end else if (expected_attrs.size() == 0 && in_acc_cnt == sent_cnt) begin
                    // Block idle: let the input register empty before acting
                    if (settle < SETTLE_CYC) begin
                        settle++;
                    end else begin
                        void'(stim_q.pop_front());
                        settle = 0;
                        if (act.kind == ACT_CFG) begin
                            ncfg = 1'b1;
                            ncd  = act.cfg_val;
                        end
                    end
                end else begin
                    settle = 0;
                end
            end
        end
        s_axis_tvalid <= nv;
        s_axis_tdata  <= nd;
        s_axis_tuser  <= nu;
        i_cfg_wr_en   <= ncfg;
        i_cfg_wr_data <= ncd;
    end

    // Receiver pacing: runs of steady flow, steady stall and per-cycle jitter
    always @(negedge i_clk) begin : pace_proc
        if (rdy_left == 0) begin
            rdy_mode = pace_t'($urandom_range(0, 2));
            rdy_left = (rdy_mode == PACE_FLOW) ? $urandom_range(20, 200) : $urandom_range(1, 40);
        end
        rdy_left--;
        case (rdy_mode)
            PACE_FLOW: m_axis_tready <= 1'b1;
            PACE_HOLD: m_axis_tready <= 1'b0;
            default:   m_axis_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Monitor: check each result transfer, predict each input transfer
    always @(posedge i_clk) begin : check_proc
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{valid_res: m_axis_tuser[2], attribute: m_axis_tuser[1:0],
                        value: m_axis_tdata, last: m_axis_tlast};
                if (expected_attrs.size() == 0) begin
                    report_err("unexpected result", got, '0);
                end else begin
                    want = expected_attrs.pop_front();
                    if (got.attribute !== want.attribute) report_err("attribute", got, want);
                    if (got.valid_res !== want.valid_res) report_err("valid_res", got, want);
                    if (got.value !== want.value) report_err("value", got, want);
                    if (got.last !== want.last) report_err("last", got, want);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                parse_status_item(s_axis_tuser, s_axis_tdata);
                in_acc_cnt <= in_acc_cnt + 1;
            end
            if (i_cfg_wr_en) tmo_ms = i_cfg_wr_data;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin : watchdog_proc
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || i_cfg_wr_en) begin
            quiet_cyc <= 0;
        end else begin
            quiet_cyc <= quiet_cyc + 1;
        end
        if (quiet_cyc == WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        // Directed lines at the reset timeout
        dir_line("R5", 16, 12, "5", 15, "385");
        dir_line("R5", 15, 12, "0", 15, "-99999");
        dir_line("R5", 15, 12, "-7", 15, "99999");
        dir_line("R6", 8, 8, "-32768", 0, "");
        dir_line("R6", 9, 8, "000123", 0, "");
        dir_line("RG", 12, 12, "2", 0, "");
        dir_line("RG", 13, 12, "", 0, "");
        dir_line("R5", 15, 12, "-", 15, "3-4");
        dir_line("R6", 8, 8, "1a", 0, "");
        dir_line("RG", 12, 12, "-0", 0, "");
        dir_line("R5", 15, 12, "65535999", 15, "32767");
        // Zero byte ends the field text
        push_text("\n,R6,1,2,3,4,5,6,7,4");
        push_byte(CHAR_NUL);
        push_text("2x-,9");
        push_byte(CHAR_CR);
        push_text("\n,R5,1,1,1,1,1,1,1,1,1,1,1,");
        push_byte(CHAR_NUL);
        push_text("5,");
        push_byte(CHAR_CR);
        // Overlong and short identifiers, bad starts
        dir_line("R55", 15, 12, "3", 15, "4");
        dir_line("R", 15, 12, "3", 15, "4");
        push_text("X\n,R6,1,1,1,1,1,1,1,5,");
        push_byte(CHAR_CR);
        push_text("\nX,R6,1,1,1,1,1,1,1,5,");
        push_byte(CHAR_CR);
        // Field number saturation and bare line ends
        dir_line("R5", 34, 12, "1", 15, "2");
        push_byte(CHAR_CR);
        push_ticks(3);
        // Idle exactly at the timeout keeps the line, one more drops it
        push_cfg(16'd20);
        push_text("\n,R6,1,2,3,4,5,6,7,8,");
        push_ticks(20);
        push_byte(CHAR_CR);
        push_text("\n,R6,1,2,3,4,5,6,7,8,");
        push_ticks(21);
        push_byte(CHAR_CR);

        // Zero timeout: any tick inside a line drops it
        push_cfg(16'd0);
        push_text("\n,R6,1,2,3,4,5,6,7,");
        push_ticks(1);
        push_text("8,9");
        push_byte(CHAR_CR);
        push_ticks(1);
        dir_line("R6", 8, 8, "12", 0, "");
        run_phase(80, 2);

        // Largest timeout: a long idle inside the line drops nothing
        push_cfg(16'hFFFF);
        push_text("\n,RG,1,1,1,1,1,1,1,1,1,1,1,");
        push_ticks(40);
        push_text("3,");
        push_byte(CHAR_CR);
        run_phase(80, 2);

        // Short timeout, with one full drain in the middle
        push_cfg(16'($urandom_range(1, 12)));
        run_phase(50, 1);
        push_drain();
        run_phase(50, 1);

        push_cfg(16'($urandom_range(0, 65535)));
        run_phase(50, 1);

        push_cfg(TIMEOUT_RESET);
        run_phase(80, 2);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!(stim_q.size() == 0 && in_acc_cnt == sent_cnt && expected_attrs.size() == 0))
            @(negedge i_clk);
        repeat (TAIL_CYC) @(negedge i_clk);
        if (expected_attrs.size() != 0) report_err("missing result", '0, expected_attrs[0]);
        if (mismatch_cnt == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: spa_status_line_parser_core.f
+incdir+src
src/spa_slp_pkg.sv
src/spa_slp_fifo.sv
src/spa_status_line_parser_core.sv
bench/tb.sv
